// ----- hdl/lfu_pkg.sv -----
// Shared types and constants of the least-frequently-used cache table.
`default_nettype none
package lfu_pkg;

	localparam int ENTRIES    = 16;
	localparam int IDX_W      = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int N_W        = $clog2(ENTRIES + 1);
	localparam int COUNT_BITS = 16;
	localparam int KEY_W      = 32;
	localparam int VAL_W      = 32;
	localparam int CAP_W      = 5;

	localparam logic [CAP_W-1:0]      CAP_RESET = CAP_W'(16);
	localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

	typedef logic [IDX_W-1:0]      idx_t;
	typedef logic [N_W-1:0]        num_t;
	typedef logic [COUNT_BITS-1:0] cnt_t;
	typedef logic [KEY_W-1:0]      key_t;
	typedef logic [VAL_W-1:0]      val_t;

	typedef enum logic {
		CMD_GET = 1'b0,
		CMD_PUT = 1'b1
	} cmd_t;

	// One table entry as presented to the scan unit.
	typedef struct packed {
		logic valid;
		logic key_eq;
		cnt_t cnt;
		idx_t rank;
		idx_t idx;
	} entry_view_t;

	// Running outcome of a scan over the table.
	typedef struct packed {
		logic found;
		idx_t match_idx;
		cnt_t match_cnt;
		idx_t match_rank;
		logic vic_found;
		idx_t vic_idx;
		cnt_t vic_cnt;
		idx_t vic_rank;
		logic free_found;
		idx_t free_idx;
		num_t n;
	} scan_res_t;

endpackage
`default_nettype wire

// ----- hdl/lfu_scan.sv -----
// Scan unit: looks at one entry per cycle while step is high; tracks match, victim, free slot and fill.
`default_nettype none
module lfu_scan
	import lfu_pkg::*;
(
	input  wire              clk,
	input  wire              arst_n,
	input  wire              clear,
	input  wire              step,
	input  wire entry_view_t ev,
	output scan_res_t        res
);

	scan_res_t res_q;
	logic      better;

	// Lower count wins; among equal counts the older rank wins.
	always_comb begin
		better = !res_q.vic_found || (ev.cnt < res_q.vic_cnt) ||
			((ev.cnt == res_q.vic_cnt) && (ev.rank < res_q.vic_rank));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_q <= '0;
		end else if (clear) begin
			res_q <= '0;
		end else if (step) begin
			if (ev.valid) begin
				res_q.n <= res_q.n + num_t'(1);
				if (ev.key_eq && !res_q.found) begin
					res_q.found      <= 1'b1;
					res_q.match_idx  <= ev.idx;
					res_q.match_cnt  <= ev.cnt;
					res_q.match_rank <= ev.rank;
				end
				if (better) begin
					res_q.vic_found <= 1'b1;
					res_q.vic_idx   <= ev.idx;
					res_q.vic_cnt   <= ev.cnt;
					res_q.vic_rank  <= ev.rank;
				end
			end else if (!res_q.free_found) begin
				res_q.free_found <= 1'b1;
				res_q.free_idx   <= ev.idx;
			end
		end
	end

	assign res = res_q;

endmodule
`default_nettype wire

// ----- hdl/lfu_cache_table.sv -----
// Top level of the least-frequently-used key-value cache table.
//
// Requests arrive on the s_ channel: s_tuser is the command (0 get, 1 put),
// s_tdata holds the key in the low 32 bits and the put value above it.
// Each request produces exactly one result on the m_ channel: m_tuser is the
// hit flag and m_tdata the stored value on a get hit, zero otherwise.
// The block handles one request at a time. After the accepting edge it scans
// the table entries in turn (ENTRIES, 16 here) to find the match, the
// replacement victim and the first free slot, then passes through an update
// state and a state that loads the output register; the next request is
// taken only once the block is back in idle, never while one is in flight.
// With a capacity of zero the scan is skipped and the request goes from
// idle straight to the state that loads the output register. The output
// register holds a result until m_tready; while it is full a finished
// request waits before the result stage and s_tready stays low. Reset
// clears every valid mark and sets the capacity to 16; cfg_we writes the
// capacity and is meant to be used only while idle.
`default_nettype none
module lfu_cache_table
	import lfu_pkg::*;
(
	input  wire               clk,
	input  wire               arst_n,
	input  wire               cfg_we,
	input  wire [CAP_W-1:0]   cfg_wdata,
	input  wire               s_tvalid,
	output logic              s_tready,
	input  wire [63:0]        s_tdata,   // lookup_key [31:0], write_value [63:32]
	input  wire               s_tuser,   // cmd
	output logic              m_tvalid,
	input  wire               m_tready,
	output logic [31:0]       m_tdata,   // read_value
	output logic              m_tuser    // hit
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_UPDATE,
		ST_DONE
	} state_t;

	state_t          state_q;
	num_t            cap_q;
	cmd_t            cmd_q;
	key_t            lkey_q;
	val_t            wval_q;
	idx_t            scan_idx_q;
	logic            res_hit_q;
	val_t            res_data_q;
	logic            m_valid_q;
	logic            m_hit_q;
	val_t            m_data_q;

	logic            valid_q [ENTRIES];
	key_t            key_q   [ENTRIES];
	val_t            value_q [ENTRIES];
	cnt_t            count_q [ENTRIES];
	idx_t            rank_q  [ENTRIES];

	logic            accept;
	num_t            cap_eff;
	entry_view_t     ev;
	scan_res_t       sres;

	logic            upd_en;
	logic            upd_new;
	logic            upd_val;
	idx_t            upd_slot;
	cnt_t            upd_cnt;
	idx_t            upd_rank;
	logic            do_drop;
	idx_t            drop_r;
	logic            upd_hit;
	val_t            upd_data;
	logic            upd_cycle;

	assign accept   = s_tvalid && s_tready;
	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = m_valid_q;
	assign m_tuser  = m_hit_q;
	assign m_tdata  = m_data_q;

	assign cap_eff = (32'(cfg_wdata) >= ENTRIES) ? num_t'(ENTRIES) : num_t'(cfg_wdata);

	// Saturated capacity is registered on configuration writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= (32'(CAP_RESET) >= ENTRIES) ? num_t'(ENTRIES) : num_t'(CAP_RESET);
		end else if (cfg_we) begin
			cap_q <= cap_eff;
		end
	end

	always_comb begin
		ev.valid  = valid_q[scan_idx_q];
		ev.key_eq = (key_q[scan_idx_q] == lkey_q);
		ev.cnt    = count_q[scan_idx_q];
		ev.rank   = rank_q[scan_idx_q];
		ev.idx    = scan_idx_q;
	end

	lfu_scan u_scan (
		.clk    (clk),
		.arst_n (arst_n),
		.clear  (accept),
		.step   (state_q == ST_SCAN),
		.ev     (ev),
		.res    (sres)
	);

	// Decision taken after the scan.
	always_comb begin
		upd_en   = 1'b0;
		upd_new  = 1'b0;
		upd_val  = 1'b0;
		upd_slot = sres.match_idx;
		upd_cnt  = cnt_t'(1);
		upd_rank = idx_t'(sres.n - num_t'(1));
		do_drop  = 1'b0;
		drop_r   = sres.match_rank;
		upd_hit  = 1'b0;
		upd_data = '0;
		if (sres.found) begin
			upd_en   = 1'b1;
			upd_val  = (cmd_q == CMD_PUT);
			upd_hit  = 1'b1;
			upd_data = (cmd_q == CMD_GET) ? value_q[sres.match_idx] : '0;
			upd_cnt  = (sres.match_cnt == COUNT_MAX) ? sres.match_cnt
				: sres.match_cnt + cnt_t'(1);
			do_drop  = 1'b1;
		end else if (cmd_q == CMD_PUT) begin
			if (sres.n < cap_q) begin
				upd_en   = sres.free_found;
				upd_new  = 1'b1;
				upd_val  = 1'b1;
				upd_slot = sres.free_idx;
				upd_rank = idx_t'(sres.n);
			end else begin
				upd_en   = sres.vic_found;
				upd_new  = 1'b1;
				upd_val  = 1'b1;
				upd_slot = sres.vic_idx;
				do_drop  = sres.vic_found;
				drop_r   = sres.vic_rank;
			end
		end
	end

	assign upd_cycle = (state_q == ST_UPDATE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < ENTRIES; i++) begin
				valid_q[i] <= 1'b0;
			end
		end else if (upd_cycle && upd_en && upd_new) begin
			valid_q[upd_slot] <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (upd_cycle && upd_en) begin
			count_q[upd_slot] <= upd_cnt;
			if (upd_new) begin
				key_q[upd_slot] <= lkey_q;
			end
			if (upd_val) begin
				value_q[upd_slot] <= wval_q;
			end
		end
		// Ranks above the removed one move down; the touched slot becomes newest.
		for (int i = 0; i < ENTRIES; i++) begin
			if (upd_cycle && upd_en && (idx_t'(i) == upd_slot)) begin
				rank_q[i] <= upd_rank;
			end else if (upd_cycle && do_drop && valid_q[i] && (rank_q[i] > drop_r)) begin
				rank_q[i] <= rank_q[i] - idx_t'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			scan_idx_q <= '0;
			m_valid_q  <= 1'b0;
			m_hit_q    <= 1'b0;
			m_data_q   <= '0;
			cmd_q      <= CMD_GET;
			lkey_q     <= '0;
			wval_q     <= '0;
			res_hit_q  <= 1'b0;
			res_data_q <= '0;
		end else begin
			// In ST_DONE the output register is handled by the state itself.
			if (m_valid_q && m_tready && (state_q != ST_DONE)) begin
				m_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						cmd_q      <= cmd_t'(s_tuser);
						lkey_q     <= s_tdata[31:0];
						wval_q     <= s_tdata[63:32];
						scan_idx_q <= '0;
						res_hit_q  <= 1'b0;
						res_data_q <= '0;
						state_q    <= (cap_q == '0) ? ST_DONE : ST_SCAN;
					end
				end
				ST_SCAN: begin
					scan_idx_q <= scan_idx_q + idx_t'(1);
					if (scan_idx_q == idx_t'(ENTRIES - 1)) begin
						state_q <= ST_UPDATE;
					end
				end
				ST_UPDATE: begin
					res_hit_q  <= upd_hit;
					res_data_q <= upd_data;
					state_q    <= ST_DONE;
				end
				ST_DONE: begin
					if (!m_valid_q || m_tready) begin
						m_valid_q <= 1'b1;
						m_hit_q   <= res_hit_q;
						m_data_q  <= res_data_q;
						state_q   <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule
`default_nettype wire
